// ===== sv/spsq_pkg.sv =====
package spsq_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int CLASS_W     = 2;
    localparam int LEN_W       = 14;
    localparam int SEQ_OUT_W   = 16;
    localparam int DEPTH_OUT_W = 5;

    // filler packet of 50 bytes after reset
    localparam logic [LEN_W-1:0] FILLER_LEN_RESET = LEN_W'(50 * 8);

    localparam logic [CLASS_W-1:0] CLASS_HIGHEST = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MIDDLE  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LOWEST  = 2'd2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    typedef enum logic [1:0] {
        KIND_ENQUEUED = 2'd0,
        KIND_DROPPED  = 2'd1,
        KIND_SERVED   = 2'd2,
        KIND_FILLER   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CLASS_W-1:0]     pkt_class;
        logic [SEQ_OUT_W-1:0]   seq_num;
        logic [LEN_W-1:0]       length;
        logic [DEPTH_OUT_W-1:0] depth;
    } rsp_t;

endpackage

// ===== sv/spsq_in_if.sv =====
interface spsq_in_if;
    import spsq_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [CLASS_W-1:0] priority_class;
    logic [LEN_W-1:0]   packet_length;

    modport source (output valid, output operation, output priority_class,
                    output packet_length, input ready);
    modport sink   (input valid, input operation, input priority_class,
                    input packet_length, output ready);
endinterface

// ===== sv/spsq_out_if.sv =====
interface spsq_out_if;
    import spsq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             result_kind;
    logic [CLASS_W-1:0]     out_class;
    logic [SEQ_OUT_W-1:0]   out_sequence;
    logic [LEN_W-1:0]       out_length;
    logic [DEPTH_OUT_W-1:0] remaining_depth;

    modport source (output valid, output result_kind, output out_class,
                    output out_sequence, output out_length,
                    output remaining_depth, input ready);
    modport sink   (input valid, input result_kind, input out_class,
                    input out_sequence, input out_length,
                    input remaining_depth, output ready);
endinterface

// ===== sv/strict_priority_three_queue_server_top.sv =====
// strict-priority server over three packet queues, class 0 highest
// in_ch carries one item per handshake: operation 0 enqueues a packet of
//   priority_class and packet_length, operation 1 asks for the next packet
// out_ch returns exactly one item per accepted input item, in order:
//   enqueued, dropped (queue full), packet served, or filler served
// cfg_we/cfg_wdata write the filler length; write it only while idle
// latency: the result is valid the cycle after the input item is accepted
// throughput: one item per cycle; an enqueue writes and a serve reads one
//   entry of the shared single-port-per-direction queue store, whose
//   registered read data feeds the output stage directly
// the output stage holds one result; a new item is taken in the same cycle
//   that the held result is taken, so a stalled receiver stalls in_ch
//   after one item
// reset: all queues empty, sequence count zero, filler length 400 bits;
//   the queue store is not cleared, an entry is only read after a write
// the store holds 3 x QUEUE_DEPTH entries of sequence and length
module strict_priority_three_queue_server_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SEQ_WIDTH   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    spsq_in_if.sink                   in_ch,
    spsq_out_if.source                out_ch,
    input  logic                      cfg_we,
    input  logic [spsq_pkg::LEN_W-1:0] cfg_wdata
);
    import spsq_pkg::*;

    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DATA_W      = SEQ_WIDTH + LEN_W;

    // filler length register
    logic [LEN_W-1:0]  filler_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    rsp_t              rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filler_reg <= FILLER_LEN_RESET;
        end
        else if (cfg_we)
        begin
            filler_reg <= cfg_wdata;
        end
    end

    // pointers, counts, sequence number and the output stage
    spsq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SEQ_WIDTH   (SEQ_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .operation      (in_ch.operation),
        .priority_class (in_ch.priority_class),
        .packet_length  (in_ch.packet_length),
        .filler_length  (filler_reg),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_rsp        (rsp)
    );

    // queue entries of all three classes, one region per class
    spsq_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_ch.result_kind     = rsp.kind;
    assign out_ch.out_class       = rsp.pkt_class;
    assign out_ch.out_sequence    = rsp.seq_num;
    assign out_ch.out_length      = rsp.length;
    assign out_ch.remaining_depth = rsp.depth;

endmodule

// ===== sv/spsq_store.sv =====
module spsq_store #(
    parameter int DEPTH  = 48,
    parameter int DATA_W = 30,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/spsq_ctrl.sv =====
module spsq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SEQ_WIDTH   = 16,
    localparam int ADDR_W = $clog2(spsq_pkg::NUM_CLASSES * QUEUE_DEPTH),
    localparam int DATA_W = SEQ_WIDTH + spsq_pkg::LEN_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [spsq_pkg::CLASS_W-1:0] priority_class,
    input  logic [spsq_pkg::LEN_W-1:0]   packet_length,
    input  logic [spsq_pkg::LEN_W-1:0]   filler_length,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [DATA_W-1:0]           mem_wdata,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  logic [DATA_W-1:0]           mem_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output spsq_pkg::rsp_t              out_rsp
);
    import spsq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0]     head_reg [NUM_CLASSES];
    logic [PTR_W-1:0]     tail_reg [NUM_CLASSES];
    logic [CNT_W-1:0]     count_reg [NUM_CLASSES];
    logic [SEQ_WIDTH-1:0] seq_reg;
    logic                 s1_valid_reg;
    rsp_t                 rsp_reg;
    logic                 from_mem_reg;

    logic                 fire;
    logic                 is_enq;
    logic [CLASS_W-1:0]   cls_eff;
    logic [CLASS_W-1:0]   served_cls;
    logic                 any_pending;
    logic [CLASS_W-1:0]   act_cls;
    logic [CNT_W-1:0]     act_count;
    logic [PTR_W-1:0]     act_head;
    logic [PTR_W-1:0]     act_tail;
    logic [PTR_W-1:0]     head_next;
    logic [PTR_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_inc;
    logic [CNT_W-1:0]     count_dec;
    logic                 full;
    logic [ADDR_W-1:0]    base;
    rsp_t                 rsp_next;
    logic                 from_mem_next;

    assign in_ready = !s1_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign is_enq   = (operation == OP_ENQUEUE);

    // class three folds onto the lowest class
    assign cls_eff = (priority_class > CLASS_LOWEST) ? CLASS_LOWEST : priority_class;

    always_comb
    begin
        any_pending = 1'b1;
        if (count_reg[0] != '0)
        begin
            served_cls = CLASS_HIGHEST;
        end
        else if (count_reg[1] != '0)
        begin
            served_cls = CLASS_MIDDLE;
        end
        else
        begin
            served_cls  = CLASS_LOWEST;
            any_pending = (count_reg[2] != '0);
        end
    end

    assign act_cls   = is_enq ? cls_eff : served_cls;
    assign act_count = count_reg[act_cls];
    assign act_head  = head_reg[act_cls];
    assign act_tail  = tail_reg[act_cls];
    assign head_next = (act_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : act_head + PTR_W'(1);
    assign tail_next = (act_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : act_tail + PTR_W'(1);
    assign count_inc = act_count + CNT_W'(1);
    assign count_dec = act_count - CNT_W'(1);
    assign full      = (act_count >= CNT_W'(QUEUE_DEPTH));
    assign base      = ADDR_W'(act_cls) * ADDR_W'(QUEUE_DEPTH);

    assign mem_we    = fire && is_enq && !full;
    assign mem_waddr = base + ADDR_W'(act_tail);
    assign mem_wdata = {seq_reg, packet_length};
    assign mem_re    = fire && !is_enq && any_pending;
    assign mem_raddr = base + ADDR_W'(act_head);

    always_comb
    begin
        rsp_next.kind      = KIND_FILLER;
        rsp_next.pkt_class = CLASS_HIGHEST;
        rsp_next.seq_num   = '0;
        rsp_next.length    = filler_length;
        rsp_next.depth     = '0;
        from_mem_next      = 1'b0;
        if (is_enq)
        begin
            rsp_next.pkt_class = act_cls;
            rsp_next.seq_num   = SEQ_OUT_W'(seq_reg);
            rsp_next.length    = packet_length;
            if (full)
            begin
                rsp_next.kind  = KIND_DROPPED;
                rsp_next.depth = DEPTH_OUT_W'(act_count);
            end
            else
            begin
                rsp_next.kind  = KIND_ENQUEUED;
                rsp_next.depth = DEPTH_OUT_W'(count_inc);
            end
        end
        else if (any_pending)
        begin
            // sequence and length come from the store's registered read data in the next cycle
            rsp_next.kind      = KIND_SERVED;
            rsp_next.pkt_class = act_cls;
            rsp_next.length    = '0;
            rsp_next.depth     = DEPTH_OUT_W'(count_dec);
            from_mem_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            seq_reg      <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                tail_reg[act_cls]  <= tail_next;
                count_reg[act_cls] <= count_inc;
                seq_reg            <= seq_reg + SEQ_WIDTH'(1);
            end
            if (mem_re)
            begin
                head_reg[act_cls]  <= head_next;
                count_reg[act_cls] <= count_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg      <= rsp_next;
            from_mem_reg <= from_mem_next;
        end
    end

    always_comb
    begin
        out_rsp = rsp_reg;
        if (from_mem_reg)
        begin
            out_rsp.seq_num = SEQ_OUT_W'(mem_rdata[DATA_W-1:LEN_W]);
            out_rsp.length  = mem_rdata[LEN_W-1:0];
        end
    end

    assign out_valid = s1_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CNT_W'(QUEUE_DEPTH) && count_reg[1] <= CNT_W'(QUEUE_DEPTH)
        && count_reg[2] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> s1_valid_reg)
        else $error("accepted item left no result");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store written and read in one cycle");

    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !mem_we |=> seq_reg == $past(seq_reg))
        else $error("sequence moved without an enqueue");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> seq_reg == SEQ_WIDTH'($past(seq_reg) + SEQ_WIDTH'(1)))
        else $error("sequence did not advance on enqueue");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import spsq_pkg::*;

    // queue size the block is built with here
    localparam int QUEUE_SLOTS = 16;
    localparam int SEQ_BITS    = 16;

    // class code 3 does not exist; the block folds it into the lowest class
    localparam logic [CLASS_W-1:0] CLASS_UNUSED = 2'd3;

    localparam logic [LEN_W-1:0] LEN_MAX     = '1;
    localparam logic [LEN_W-1:0] LEN_NOMINAL = LEN_W'(1500 * 8);

    // one packet waiting in a class queue of the predictor
    typedef struct packed {
        logic [SEQ_OUT_W-1:0] seq_num;
        logic [LEN_W-1:0]     length;
    } held_pkt_t;

    // predicts each result of the server and compares what comes back
    class sched_scoreboard;
        held_pkt_t            backlog [NUM_CLASSES][$];
        rsp_t                 awaited [$];
        logic [SEQ_OUT_W-1:0] next_seq;
        logic [LEN_W-1:0]     filler_len;
        int unsigned          errors;

        function new();
            next_seq   = '0;
            filler_len = FILLER_LEN_RESET;
            errors     = 0;
        endfunction

        function void set_filler(logic [LEN_W-1:0] value);
            filler_len = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // work out the result of one accepted input item
        function void note_input(logic op, logic [CLASS_W-1:0] cls,
                                 logic [LEN_W-1:0] len);
            rsp_t      r;
            held_pkt_t pkt;
            int        q;
            r = '0;
            if (op == OP_ENQUEUE)
            begin
                q           = (cls > CLASS_LOWEST) ? int'(CLASS_LOWEST) : int'(cls);
                r.pkt_class = CLASS_W'(q);
                r.seq_num   = next_seq;
                r.length    = len;
                if (backlog[q].size() >= QUEUE_SLOTS)
                begin
                    r.kind  = KIND_DROPPED;
                    r.depth = DEPTH_OUT_W'(backlog[q].size());
                end
                else
                begin
                    pkt.seq_num = next_seq;
                    pkt.length  = len;
                    backlog[q].insert(backlog[q].size(), pkt);
                    next_seq = next_seq + SEQ_OUT_W'(1);
                    r.kind   = KIND_ENQUEUED;
                    r.depth  = DEPTH_OUT_W'(backlog[q].size());
                end
            end
            else
            begin
                // lowest-numbered class with something waiting wins
                q = -1;
                for (int c = NUM_CLASSES - 1; c >= 0; c--)
                begin
                    if (backlog[c].size() != 0)
                        q = c;
                end
                if (q >= 0)
                begin
                    pkt = backlog[q][0];
                    backlog[q].delete(0);
                    r.kind      = KIND_SERVED;
                    r.pkt_class = CLASS_W'(q);
                    r.seq_num   = pkt.seq_num;
                    r.length    = pkt.length;
                    r.depth     = DEPTH_OUT_W'(backlog[q].size());
                end
                else
                begin
                    r.kind   = KIND_FILLER;
                    r.length = filler_len;
                end
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("result_kind unexpected item, got %0d", got.kind);
                errors++;
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (got.kind != want.kind)
            begin
                $error("result_kind expected %0d got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.pkt_class !== want.pkt_class)
            begin
                $error("out_class expected %0d got %0d", want.pkt_class, got.pkt_class);
                errors++;
            end
            if (got.seq_num !== want.seq_num)
            begin
                $error("out_sequence expected %0d got %0d", want.seq_num, got.seq_num);
                errors++;
            end
            if (got.length !== want.length)
            begin
                $error("out_length expected %0d got %0d", want.length, got.length);
                errors++;
            end
            if (got.depth !== want.depth)
            begin
                $error("remaining_depth expected %0d got %0d", want.depth, got.depth);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    spsq_in_if  in_ch ();
    spsq_out_if out_ch ();

    sched_scoreboard sb;

    // items left in the current sender burst
    int burst_left = 0;

    strict_priority_three_queue_server_top #(
        .QUEUE_DEPTH (QUEUE_SLOTS),
        .SEQ_WIDTH   (SEQ_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(logic op, logic [CLASS_W-1:0] cls, logic [LEN_W-1:0] len);
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.priority_class <= cls;
        in_ch.packet_length  <= len;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_input(op, cls, len);
    endtask

    // sender works in bursts; between bursts valid drops for a random gap,
    // and a zero gap now and then merges two bursts into one long stretch
    task automatic issue(logic op, logic [CLASS_W-1:0] cls, logic [LEN_W-1:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        send_item(op, cls, len);
        burst_left--;
    endtask

    // write the filler length once the block has nothing left to return
    task automatic write_filler(logic [LEN_W-1:0] value);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        // result stage is one deep; the idle wait below covers it
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_filler(value);
    endtask

    // lengths: mostly legal sizes, with the edges and out-of-range values mixed in
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEN_MAX;
            2:       return LEN_NOMINAL;
            3:       return LEN_W'($urandom_range(0, 16383));
            default: return LEN_W'($urandom_range(0, 12000));
        endcase
    endfunction

    // random traffic in stretches that lean towards enqueue (queues fill,
    // drops appear) or towards serve (queues drain, fillers appear)
    task automatic run_random(int count);
        int                 enq_pct;
        int                 stretch;
        logic               op;
        logic [CLASS_W-1:0] cls;
        stretch = 0;
        enq_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (stretch == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                stretch = $urandom_range(10, 50);
            end
            stretch--;
            op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_SERVE;
            cls = CLASS_W'($urandom_range(0, 3));
            issue(op, cls, pick_length());
        end
    endtask

    // receiver: ready follows its own pattern, switching between always
    // ready, half the cycles and a quarter of the cycles
    initial
    begin
        int ready_pct;
        out_ch.ready <= 1'b0;
        forever
        begin
            case ($urandom_range(0, 2))
                0:       ready_pct = 100;
                1:       ready_pct = 50;
                default: ready_pct = 25;
            endcase
            repeat ($urandom_range(8, 40))
            begin
                @(posedge clk);
                out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // every result taken by the receiver goes to the scoreboard
    always @(posedge clk)
    begin
        rsp_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind      = kind_t'(out_ch.result_kind);
            got.pkt_class = out_ch.out_class;
            got.seq_num   = out_ch.out_sequence;
            got.length    = out_ch.out_length;
            got.depth     = out_ch.remaining_depth;
            sb.check_result(got);
        end
    end

    // stimulus
    initial
    begin
        sb = new();
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.operation      <= OP_ENQUEUE;
        in_ch.priority_class <= CLASS_HIGHEST;
        in_ch.packet_length  <= '0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing queued yet: filler at its reset length
        issue(OP_SERVE, CLASS_HIGHEST, '0);
        // one packet per class, plus a second lowest one through class code 3
        issue(OP_ENQUEUE, CLASS_LOWEST, LEN_W'(12001));
        issue(OP_ENQUEUE, CLASS_UNUSED, LEN_NOMINAL);
        issue(OP_ENQUEUE, CLASS_MIDDLE, LEN_MAX);
        issue(OP_ENQUEUE, CLASS_HIGHEST, '0);
        // served highest class first, oldest first within a class
        repeat (4) issue(OP_SERVE, CLASS_UNUSED, LEN_MAX);
        issue(OP_SERVE, CLASS_MIDDLE, LEN_NOMINAL);
        // fill the lowest queue through the unused class code; the last one drops
        for (int i = 0; i <= QUEUE_SLOTS; i++)
        begin
            issue(OP_ENQUEUE, CLASS_UNUSED, LEN_W'(i * 1021));
        end

        // several filler lengths, both extremes among them
        write_filler('0);
        run_random(200);
        write_filler(LEN_MAX);
        run_random(200);
        write_filler(LEN_W'($urandom_range(1, 16382)));
        run_random(200);
        write_filler(LEN_W'($urandom_range(1, 16382)));
        run_random(200);

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // keep watching to catch any stray result
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // safety net in case the block hangs
    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
